/* src/sip_pkg.sv */
// shared constants for the segment intersection point block
// no dependencies
`default_nettype none

package sip_pkg;

   // default width of one coordinate, two's complement
   localparam int COORD_BITS = 16;

   // number of side bits that travel beside the divider lanes
   localparam int TAG_BITS = 3;

   // positions of the side bits
   localparam int TAG_MEET = 0;
   localparam int TAG_PAR  = 1;
   localparam int TAG_USE  = 2;

endpackage

`default_nettype wire

/* src/sip_if.sv */
// valid/ready channel interfaces for segment pairs and intersection results
// depends on sip_pkg
`default_nettype none

interface sip_req_if #(
   parameter int COORD_BITS = sip_pkg::COORD_BITS
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] a_start_x;
   logic signed [COORD_BITS-1:0] a_start_y;
   logic signed [COORD_BITS-1:0] a_end_x;
   logic signed [COORD_BITS-1:0] a_end_y;
   logic signed [COORD_BITS-1:0] b_start_x;
   logic signed [COORD_BITS-1:0] b_start_y;
   logic signed [COORD_BITS-1:0] b_end_x;
   logic signed [COORD_BITS-1:0] b_end_y;

   modport source (
      output valid, a_start_x, a_start_y, a_end_x, a_end_y,
             b_start_x, b_start_y, b_end_x, b_end_y,
      input  ready
   );
   modport sink (
      input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
             b_start_x, b_start_y, b_end_x, b_end_y,
      output ready
   );
endinterface

interface sip_rsp_if #(
   parameter int COORD_BITS = sip_pkg::COORD_BITS
);
   logic                         valid;
   logic                         ready;
   logic                         segments_meet;
   logic                         lines_parallel;
   logic signed [COORD_BITS-1:0] cross_x;
   logic signed [COORD_BITS-1:0] cross_y;

   modport source (
      output valid, segments_meet, lines_parallel, cross_x, cross_y,
      input  ready
   );
   modport sink (
      input  valid, segments_meet, lines_parallel, cross_x, cross_y,
      output ready
   );
endinterface

`default_nettype wire

/* src/sip_div.sv */
// pipelined two-lane restoring divider, one quotient bit per stage
// depends on sip_pkg
`default_nettype none

module sip_div #(
   parameter int COORD_BITS = sip_pkg::COORD_BITS,
   parameter int TAG_BITS   = sip_pkg::TAG_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic [TAG_BITS-1:0]       in_tag,
   input  wire logic [3*COORD_BITS+5:0]   in_num_x,
   input  wire logic [3*COORD_BITS+5:0]   in_num_y,
   input  wire logic [3*COORD_BITS+5:0]   in_den_x,
   input  wire logic [3*COORD_BITS+5:0]   in_den_y,
   input  wire logic                      in_neg_x,
   input  wire logic                      in_neg_y,
   output logic                           out_valid,
   output logic [TAG_BITS-1:0]            out_tag,
   output logic [COORD_BITS:0]            out_quo_x,
   output logic [COORD_BITS:0]            out_quo_y,
   output logic                           out_ovf_x,
   output logic                           out_ovf_y,
   output logic                           out_neg_x,
   output logic                           out_neg_y
);

   localparam int W = 3 * COORD_BITS + 6;
   localparam int K = COORD_BITS + 1;

   logic [W-1:0]        num_lane [0:1];
   logic [W-1:0]        den_lane [0:1];
   logic                neg_lane [0:1];

   logic [W-1:0]        rem_ff  [0:K][0:1];
   logic [W-1:0]        den_ff  [0:K][0:1];
   logic [K-1:0]        quo_ff  [0:K][0:1];
   logic                ovf_ff  [0:K][0:1];
   logic                neg_ff  [0:K][0:1];
   logic                vld_ff  [0:K];
   logic [TAG_BITS-1:0] tag_ff  [0:K];

   assign num_lane[0] = in_num_x;
   assign num_lane[1] = in_num_y;
   assign den_lane[0] = in_den_x;
   assign den_lane[1] = in_den_y;
   assign neg_lane[0] = in_neg_x;
   assign neg_lane[1] = in_neg_y;

   // entry stage: catch quotients that do not fit in K bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= in_tag;
         for (int l = 0; l < 2; l++) begin
            rem_ff[0][l] <= num_lane[l];
            den_ff[0][l] <= den_lane[l];
            quo_ff[0][l] <= '0;
            ovf_ff[0][l] <= num_lane[l] >= (den_lane[l] << K);
            neg_ff[0][l] <= neg_lane[l];
         end
      end
   end

   for (genvar s = 1; s <= K; s++) begin : g_stage
      logic [W-1:0] trial  [0:1];
      logic         fits   [0:1];
      logic [K-1:0] quo_in [0:1];

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            trial[l]       = den_ff[s-1][l] << (K - s);
            fits[l]        = rem_ff[s-1][l] >= trial[l];
            quo_in[l]      = quo_ff[s-1][l];
            quo_in[l][K-s] = fits[l];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[s] <= tag_ff[s-1];
            for (int l = 0; l < 2; l++) begin
               rem_ff[s][l] <= fits[l] ? rem_ff[s-1][l] - trial[l] : rem_ff[s-1][l];
               den_ff[s][l] <= den_ff[s-1][l];
               quo_ff[s][l] <= quo_in[l];
               ovf_ff[s][l] <= ovf_ff[s-1][l];
               neg_ff[s][l] <= neg_ff[s-1][l];
            end
         end
      end
   end

   assign out_valid = vld_ff[K];
   assign out_tag   = tag_ff[K];
   assign out_quo_x = quo_ff[K][0];
   assign out_quo_y = quo_ff[K][1];
   assign out_ovf_x = ovf_ff[K][0];
   assign out_ovf_y = ovf_ff[K][1];
   assign out_neg_x = neg_ff[K][0];
   assign out_neg_y = neg_ff[K][1];

endmodule

`default_nettype wire

/* src/segment_intersection_point_top.sv */
// segment intersection point: orientation test plus rounded crossing point
// depends on sip_pkg, sip_if (sip_req_if, sip_rsp_if) and sip_div
//
//   channel | dir | handshake          | payload
//   req_chan| in  | valid/ready        | two segments, eight signed coordinates
//   rsp_chan| out | valid/ready        | meet flag, parallel flag, crossing x/y
//
// one segment pair per cycle while the output is not stalled, fully pipelined;
// the divider resolves one quotient bit per stage
// all stages move together on one enable; a stalled result holds in the output
// register and the pipe only freezes while that register is full and not taken
// reset clears the valid bits only; data registers are not reset
`default_nettype none

module segment_intersection_point_top #(
   parameter int COORD_BITS = sip_pkg::COORD_BITS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   sip_req_if.sink      req_chan,
   sip_rsp_if.source    rsp_chan
);

   localparam int C  = COORD_BITS;
   localparam int D  = C + 1;         // coordinate difference
   localparam int P  = 2 * D;         // product of two differences
   localparam int CW = D + C + 1;     // line constant c1, c2
   localparam int DW = 2 * D + 1;     // determinant and orientation value
   localparam int NP = D + CW;        // numerator product
   localparam int NW = NP + 1;        // numerator
   localparam int W  = 3 * C + 6;     // divider word
   localparam int K  = C + 1;         // quotient bits
   localparam int TB = sip_pkg::TAG_BITS;

   localparam logic [K-1:0] HALF = K'(1) << (C - 1);
   localparam logic [C-1:0] CMAX = {1'b0, {(C-1){1'b1}}};

   logic en;

   // ---------------- stage 1: input register ----------------
   logic                s1_vld_ff;
   logic signed [C-1:0] s1_ax0_ff, s1_ay0_ff, s1_ax1_ff, s1_ay1_ff;
   logic signed [C-1:0] s1_bx0_ff, s1_by0_ff, s1_bx1_ff, s1_by1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ax0_ff <= req_chan.a_start_x;
         s1_ay0_ff <= req_chan.a_start_y;
         s1_ax1_ff <= req_chan.a_end_x;
         s1_ay1_ff <= req_chan.a_end_y;
         s1_bx0_ff <= req_chan.b_start_x;
         s1_by0_ff <= req_chan.b_start_y;
         s1_bx1_ff <= req_chan.b_end_x;
         s1_by1_ff <= req_chan.b_end_y;
      end
   end

   // ---------------- stage 2: differences and bounding box checks ----------------
   logic                s2_vld_ff;
   logic signed [D-1:0] s2_a1_ff, s2_b1_ff, s2_a2_ff, s2_b2_ff;
   logic signed [D-1:0] s2_e1x_ff, s2_e1y_ff, s2_e2x_ff, s2_e2y_ff;
   logic signed [D-1:0] s2_e3x_ff, s2_e3y_ff, s2_e4x_ff, s2_e4y_ff;
   logic signed [C-1:0] s2_ax0_ff, s2_ay0_ff, s2_bx0_ff, s2_by0_ff;
   logic [3:0]          s2_win_ff;
   logic [3:0]          s2_win_in;

   // q lies in the box spanned by p and r
   function automatic logic in_box(
      input logic signed [C-1:0] px, input logic signed [C-1:0] py,
      input logic signed [C-1:0] qx, input logic signed [C-1:0] qy,
      input logic signed [C-1:0] rx, input logic signed [C-1:0] ry
   );
      logic okx, oky;
      okx = (qx >= px && qx <= rx) || (qx >= rx && qx <= px);
      oky = (qy >= py && qy <= ry) || (qy >= ry && qy <= py);
      return okx && oky;
   endfunction

   always_comb begin
      s2_win_in[0] = in_box(s1_ax0_ff, s1_ay0_ff, s1_bx0_ff, s1_by0_ff, s1_ax1_ff, s1_ay1_ff);
      s2_win_in[1] = in_box(s1_ax0_ff, s1_ay0_ff, s1_bx1_ff, s1_by1_ff, s1_ax1_ff, s1_ay1_ff);
      s2_win_in[2] = in_box(s1_bx0_ff, s1_by0_ff, s1_ax0_ff, s1_ay0_ff, s1_bx1_ff, s1_by1_ff);
      s2_win_in[3] = in_box(s1_bx0_ff, s1_by0_ff, s1_ax1_ff, s1_ay1_ff, s1_bx1_ff, s1_by1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_a1_ff  <= D'(s1_ay1_ff) - D'(s1_ay0_ff);
         s2_b1_ff  <= D'(s1_ax0_ff) - D'(s1_ax1_ff);
         s2_a2_ff  <= D'(s1_by1_ff) - D'(s1_by0_ff);
         s2_b2_ff  <= D'(s1_bx0_ff) - D'(s1_bx1_ff);
         s2_e1x_ff <= D'(s1_bx0_ff) - D'(s1_ax1_ff);
         s2_e1y_ff <= D'(s1_by0_ff) - D'(s1_ay1_ff);
         s2_e2x_ff <= D'(s1_bx1_ff) - D'(s1_ax1_ff);
         s2_e2y_ff <= D'(s1_by1_ff) - D'(s1_ay1_ff);
         s2_e3x_ff <= D'(s1_ax0_ff) - D'(s1_bx1_ff);
         s2_e3y_ff <= D'(s1_ay0_ff) - D'(s1_by1_ff);
         s2_e4x_ff <= D'(s1_ax1_ff) - D'(s1_bx1_ff);
         s2_e4y_ff <= D'(s1_ay1_ff) - D'(s1_by1_ff);
         s2_ax0_ff <= s1_ax0_ff;
         s2_ay0_ff <= s1_ay0_ff;
         s2_bx0_ff <= s1_bx0_ff;
         s2_by0_ff <= s1_by0_ff;
         s2_win_ff <= s2_win_in;
      end
   end

   // ---------------- stage 3: first products ----------------
   // orientation of r against p->q: (qy-py)*(rx-qx) - (qx-px)*(ry-qy)
   logic                 s3_vld_ff;
   logic signed [P-1:0]  s3_op_ff [0:3];
   logic signed [P-1:0]  s3_oq_ff [0:3];
   logic signed [CW-2:0] s3_c1p_ff, s3_c1q_ff, s3_c2p_ff, s3_c2q_ff;
   logic signed [P-1:0]  s3_dp_ff, s3_dq_ff;
   logic signed [D-1:0]  s3_a1_ff, s3_b1_ff, s3_a2_ff, s3_b2_ff;
   logic [3:0]           s3_win_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // a direction is (ay1-ay0, ax1-ax0) = (a1, -b1), b likewise
         s3_op_ff[0] <= P'(s2_a1_ff) * P'(s2_e1x_ff);
         s3_oq_ff[0] <= -(P'(s2_b1_ff) * P'(s2_e1y_ff));
         s3_op_ff[1] <= P'(s2_a1_ff) * P'(s2_e2x_ff);
         s3_oq_ff[1] <= -(P'(s2_b1_ff) * P'(s2_e2y_ff));
         s3_op_ff[2] <= P'(s2_a2_ff) * P'(s2_e3x_ff);
         s3_oq_ff[2] <= -(P'(s2_b2_ff) * P'(s2_e3y_ff));
         s3_op_ff[3] <= P'(s2_a2_ff) * P'(s2_e4x_ff);
         s3_oq_ff[3] <= -(P'(s2_b2_ff) * P'(s2_e4y_ff));
         s3_c1p_ff   <= (CW-1)'(s2_a1_ff) * (CW-1)'(s2_ax0_ff);
         s3_c1q_ff   <= (CW-1)'(s2_b1_ff) * (CW-1)'(s2_ay0_ff);
         s3_c2p_ff   <= (CW-1)'(s2_a2_ff) * (CW-1)'(s2_bx0_ff);
         s3_c2q_ff   <= (CW-1)'(s2_b2_ff) * (CW-1)'(s2_by0_ff);
         s3_dp_ff    <= P'(s2_a1_ff) * P'(s2_b2_ff);
         s3_dq_ff    <= P'(s2_a2_ff) * P'(s2_b1_ff);
         s3_a1_ff    <= s2_a1_ff;
         s3_b1_ff    <= s2_b1_ff;
         s3_a2_ff    <= s2_a2_ff;
         s3_b2_ff    <= s2_b2_ff;
         s3_win_ff   <= s2_win_ff;
      end
   end

   // ---------------- stage 4: orientation signs, meet, line constants ----------------
   logic                 s4_vld_ff;
   logic                 s4_meet_ff;
   logic signed [CW-1:0] s4_c1_ff, s4_c2_ff;
   logic signed [DW-1:0] s4_det_ff;
   logic signed [D-1:0]  s4_a1_ff, s4_b1_ff, s4_a2_ff, s4_b2_ff;
   logic signed [DW-1:0] orv  [0:3];
   logic [3:0]           or_zero, or_pos;
   logic                 s4_meet_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         orv[i]     = DW'(s3_op_ff[i]) - DW'(s3_oq_ff[i]);
         or_zero[i] = orv[i] == '0;
         or_pos[i]  = !orv[i][DW-1] && !or_zero[i];
      end
      // general crossing: signs differ on both segments
      s4_meet_in = ((or_zero[0] != or_zero[1]) || (or_pos[0] != or_pos[1]))
                && ((or_zero[2] != or_zero[3]) || (or_pos[2] != or_pos[3]));
      // collinear touch: endpoint lies on the other segment
      for (int i = 0; i < 4; i++) begin
         s4_meet_in = s4_meet_in || (or_zero[i] && s3_win_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_meet_ff <= s4_meet_in;
         s4_c1_ff   <= CW'(s3_c1p_ff) + CW'(s3_c1q_ff);
         s4_c2_ff   <= CW'(s3_c2p_ff) + CW'(s3_c2q_ff);
         s4_det_ff  <= DW'(s3_dp_ff) - DW'(s3_dq_ff);
         s4_a1_ff   <= s3_a1_ff;
         s4_b1_ff   <= s3_b1_ff;
         s4_a2_ff   <= s3_a2_ff;
         s4_b2_ff   <= s3_b2_ff;
      end
   end

   // ---------------- stage 5: cramer numerator products ----------------
   logic                 s5_vld_ff;
   logic                 s5_meet_ff, s5_par_ff;
   logic signed [NP-1:0] s5_xp_ff, s5_xq_ff, s5_yp_ff, s5_yq_ff;
   logic signed [DW-1:0] s5_det_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (en) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_meet_ff <= s4_meet_ff;
         s5_par_ff  <= s4_det_ff == '0;
         s5_xp_ff   <= NP'(s4_b2_ff) * NP'(s4_c1_ff);
         s5_xq_ff   <= NP'(s4_b1_ff) * NP'(s4_c2_ff);
         s5_yp_ff   <= NP'(s4_a1_ff) * NP'(s4_c2_ff);
         s5_yq_ff   <= NP'(s4_a2_ff) * NP'(s4_c1_ff);
         s5_det_ff  <= s4_det_ff;
      end
   end

   // ---------------- stage 6: numerators ----------------
   logic                 s6_vld_ff;
   logic                 s6_meet_ff, s6_par_ff;
   logic signed [NW-1:0] s6_nx_ff, s6_ny_ff;
   logic signed [DW-1:0] s6_det_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (en) begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_meet_ff <= s5_meet_ff;
         s6_par_ff  <= s5_par_ff;
         s6_nx_ff   <= NW'(s5_xp_ff) - NW'(s5_xq_ff);
         s6_ny_ff   <= NW'(s5_yp_ff) - NW'(s5_yq_ff);
         s6_det_ff  <= s5_det_ff;
      end
   end

   // ---------------- stage 7: magnitudes for round half away from zero ----------------
   // q = (2|n| + |d|) / (2|d|), sign from the operand signs
   logic                 s7_vld_ff;
   logic [TB-1:0]        s7_tag_ff;
   logic [W-1:0]         s7_numx_ff, s7_numy_ff, s7_den_ff;
   logic                 s7_negx_ff, s7_negy_ff;
   logic [W-1:0]         mag_x, mag_y, mag_d;
   logic [TB-1:0]        s7_tag_in;

   always_comb begin
      mag_x = s6_nx_ff[NW-1]  ? W'(-s6_nx_ff)  : W'(s6_nx_ff);
      mag_y = s6_ny_ff[NW-1]  ? W'(-s6_ny_ff)  : W'(s6_ny_ff);
      mag_d = s6_det_ff[DW-1] ? W'(-s6_det_ff) : W'(s6_det_ff);
      s7_tag_in = '0;
      s7_tag_in[sip_pkg::TAG_MEET] = s6_meet_ff;
      s7_tag_in[sip_pkg::TAG_PAR]  = s6_par_ff;
      s7_tag_in[sip_pkg::TAG_USE]  = s6_meet_ff && !s6_par_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (en) begin
         s7_vld_ff <= s6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_tag_ff  <= s7_tag_in;
         s7_numx_ff <= (mag_x << 1) + mag_d;
         s7_numy_ff <= (mag_y << 1) + mag_d;
         s7_den_ff  <= mag_d << 1;
         s7_negx_ff <= s6_nx_ff[NW-1] ^ s6_det_ff[DW-1];
         s7_negy_ff <= s6_ny_ff[NW-1] ^ s6_det_ff[DW-1];
      end
   end

   // ---------------- divider: K + 1 stages ----------------
   logic          dv_valid;
   logic [TB-1:0] dv_tag;
   logic [K-1:0]  dv_quo_x, dv_quo_y;
   logic          dv_ovf_x, dv_ovf_y, dv_neg_x, dv_neg_y;

   sip_div #(
      .COORD_BITS (COORD_BITS),
      .TAG_BITS   (TB)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s7_vld_ff),
      .in_tag    (s7_tag_ff),
      .in_num_x  (s7_numx_ff),
      .in_num_y  (s7_numy_ff),
      .in_den_x  (s7_den_ff),
      .in_den_y  (s7_den_ff),
      .in_neg_x  (s7_negx_ff),
      .in_neg_y  (s7_negy_ff),
      .out_valid (dv_valid),
      .out_tag   (dv_tag),
      .out_quo_x (dv_quo_x),
      .out_quo_y (dv_quo_y),
      .out_ovf_x (dv_ovf_x),
      .out_ovf_y (dv_ovf_y),
      .out_neg_x (dv_neg_x),
      .out_neg_y (dv_neg_y)
   );

   // ---------------- output register: saturate, sign, no-point code ----------------
   logic          rsp_vld_ff;
   logic          rsp_meet_ff, rsp_par_ff;
   logic [C-1:0]  rsp_x_ff, rsp_y_ff;
   logic [C-1:0]  res_x_in, res_y_in;

   function automatic logic [C-1:0] finish(
      input logic [K-1:0] quo, input logic ovf, input logic neg, input logic use_pt
   );
      logic         big;
      logic [C-1:0] mag;
      logic [C-1:0] res;
      big = ovf || quo >= HALF;
      mag = big ? HALF[C-1:0] : quo[C-1:0];
      if (!use_pt) begin
         res = '1;                        // no point: -1
      end else if (neg) begin
         res = -mag;
      end else begin
         res = big ? CMAX : mag;
      end
      return res;
   endfunction

   always_comb begin
      res_x_in = finish(dv_quo_x, dv_ovf_x, dv_neg_x, dv_tag[sip_pkg::TAG_USE]);
      res_y_in = finish(dv_quo_y, dv_ovf_y, dv_neg_y, dv_tag[sip_pkg::TAG_USE]);
   end

   // whole pipe advances unless a finished result is waiting to transfer
   assign en = !rsp_vld_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_meet_ff <= dv_tag[sip_pkg::TAG_MEET];
         rsp_par_ff  <= dv_tag[sip_pkg::TAG_PAR];
         rsp_x_ff    <= res_x_in;
         rsp_y_ff    <= res_y_in;
      end
   end

   assign req_chan.ready          = en;
   assign rsp_chan.valid          = rsp_vld_ff;
   assign rsp_chan.segments_meet  = rsp_meet_ff;
   assign rsp_chan.lines_parallel = rsp_par_ff;
   assign rsp_chan.cross_x        = rsp_x_ff;
   assign rsp_chan.cross_y        = rsp_y_ff;

endmodule

`default_nettype wire

/* tb/sip_tb_if.sv */
// no extra interfaces needed: the testbench uses sip_req_if and sip_rsp_if from src/sip_if.sv
// this file holds a small shared type set for the testbench, depends on sip_pkg
`default_nettype none

package sip_tb_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = sip_pkg::COORD_BITS;

   typedef logic signed [CB-1:0] coord_type;

   typedef struct packed {
      coord_type ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
   } seg_pair_type;

   typedef struct packed {
      logic      meet;
      logic      parallel;
      coord_type px;
      coord_type py;
   } crossing_type;
endpackage

`default_nettype wire

/* tb/segment_intersection_point_top_tb.sv */
// testbench for segment_intersection_point_top: directed table then random pairs,
// every result checked in order against typed-in values or a local crossing predictor
// depends on sip_pkg, sip_if, sip_tb_pkg and the block itself
`default_nettype none

module segment_intersection_point_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef sip_tb_pkg::coord_type    coord_type;
   typedef sip_tb_pkg::seg_pair_type seg_pair_type;
   typedef sip_tb_pkg::crossing_type crossing_type;

   localparam int CB        = sip_tb_pkg::CB;
   localparam int LATENCY   = CB + 10;
   localparam int WDOG_MAX  = 2000;
   localparam int N_RANDOM  = 1600;
   localparam longint CMAXV = (64'sd1 <<< (CB - 1)) - 1;
   localparam coord_type CHI  = coord_type'(CMAXV);
   localparam coord_type CLO  = coord_type'(-CMAXV - 1);
   localparam coord_type NONE = coord_type'(-1);

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   sip_req_if req_chan ();
   sip_rsp_if rsp_chan ();

   segment_intersection_point_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   // one directed row; has_expect marks rows whose result is typed in
   typedef struct {
      seg_pair_type pair;
      bit           has_expect;
      crossing_type want;
   } vector_row_type;

   crossing_type   expected_crossings[$];
   vector_row_type directed[$];
   int             n_errors = 0;
   int             idle_cycles = 0;
   bit             sender_done = 1'b0;

   // orientation sign of r against line p->q: 0 collinear, 1 cw, 2 ccw
   function automatic int turn_of(longint px, longint py, longint qx, longint qy,
                                  longint rx, longint ry);
      longint v;
      v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
      return (v == 0) ? 0 : ((v > 0) ? 1 : 2);
   endfunction

   // q inside the bounding box of p and r
   function automatic bit on_box(longint px, longint py, longint qx, longint qy,
                                 longint rx, longint ry);
      longint lox, hix, loy, hiy;
      lox = (px < rx) ? px : rx;
      hix = (px < rx) ? rx : px;
      loy = (py < ry) ? py : ry;
      hiy = (py < ry) ? ry : py;
      return qx >= lox && qx <= hix && qy >= loy && qy <= hiy;
   endfunction

   // quotient rounded half away from zero, saturated to the coordinate range
   function automatic coord_type round_quot(longint n, longint d);
      bit     neg;
      longint q;
      neg = 1'b0;
      if (d < 0) begin
         d = -d;
         n = -n;
      end
      if (n < 0) begin
         neg = 1'b1;
         n = -n;
      end
      q = (2 * n + d) / (2 * d);
      if (q > CMAXV + 1) q = CMAXV + 1;
      if (neg) return coord_type'(-q);
      return (q > CMAXV) ? CHI : coord_type'(q);
   endfunction

   function automatic crossing_type predict_crossing(seg_pair_type s);
      longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
      longint a1, b1, c1, a2, b2, c2, det;
      int o1, o2, o3, o4;
      crossing_type r;
      ax0 = s.ax0; ay0 = s.ay0; ax1 = s.ax1; ay1 = s.ay1;
      bx0 = s.bx0; by0 = s.by0; bx1 = s.bx1; by1 = s.by1;
      o1 = turn_of(ax0, ay0, ax1, ay1, bx0, by0);
      o2 = turn_of(ax0, ay0, ax1, ay1, bx1, by1);
      o3 = turn_of(bx0, by0, bx1, by1, ax0, ay0);
      o4 = turn_of(bx0, by0, bx1, by1, ax1, ay1);
      r.meet = (o1 != o2 && o3 != o4)
         || (o1 == 0 && on_box(ax0, ay0, bx0, by0, ax1, ay1))
         || (o2 == 0 && on_box(ax0, ay0, bx1, by1, ax1, ay1))
         || (o3 == 0 && on_box(bx0, by0, ax0, ay0, bx1, by1))
         || (o4 == 0 && on_box(bx0, by0, ax1, ay1, bx1, by1));
      a1 = ay1 - ay0;
      b1 = ax0 - ax1;
      c1 = a1 * ax0 + b1 * ay0;
      a2 = by1 - by0;
      b2 = bx0 - bx1;
      c2 = a2 * bx0 + b2 * by0;
      det = a1 * b2 - a2 * b1;
      r.parallel = (det == 0);
      r.px = NONE;
      r.py = NONE;
      if (r.meet && det != 0) begin
         r.px = round_quot(b2 * c1 - b1 * c2, det);
         r.py = round_quot(a1 * c2 - a2 * c1, det);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      n_errors++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   // append one expected result at the tail of the scoreboard
   function automatic void expect_result(crossing_type c);
      expected_crossings.insert(expected_crossings.size(), c);
   endfunction

   // append one row to the directed table
   function automatic void add_row(seg_pair_type pair, bit has_expect, crossing_type want);
      vector_row_type row;
      row.pair       = pair;
      row.has_expect = has_expect;
      row.want       = want;
      directed.insert(directed.size(), row);
   endfunction

   function automatic seg_pair_type mk(int ax0, int ay0, int ax1, int ay1,
                                       int bx0, int by0, int bx1, int by1);
      seg_pair_type s;
      s = '{coord_type'(ax0), coord_type'(ay0), coord_type'(ax1), coord_type'(ay1),
            coord_type'(bx0), coord_type'(by0), coord_type'(bx1), coord_type'(by1)};
      return s;
   endfunction

   function automatic coord_type rand_coord(int span);
      if (span == 0) return coord_type'($urandom);
      return coord_type'($signed($urandom_range(2 * span)) - span);
   endfunction

   // random pair: noise at three spans, crossing segments built around a center, or shifted copies
   function automatic seg_pair_type rand_pair();
      seg_pair_type s;
      int span, cx, cy, k;
      k = $urandom_range(9);
      span = (k < 2) ? 0 : ((k < 5) ? 100 : 16000);
      s = {rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
           rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span)};
      if (k >= 5 && k < 8) begin
         // mirror endpoints through a common center so the segments cross
         cx = $signed($urandom_range(2000)) - 1000;
         cy = $signed($urandom_range(2000)) - 1000;
         s.ax1 = coord_type'(2 * cx - s.ax0);
         s.ay1 = coord_type'(2 * cy - s.ay0);
         s.bx1 = coord_type'(2 * cx - s.bx0);
         s.by1 = coord_type'(2 * cy - s.by0);
      end else if (k == 8) begin
         // collinear or parallel: b shifted copy of a
         s.bx0 = s.ax0 + coord_type'($urandom_range(3));
         s.by0 = s.ay0;
         s.bx1 = s.ax1 + s.bx0 - s.ax0;
         s.by1 = s.ay1;
      end
      return s;
   endfunction

   initial begin
      crossing_type no_hit;
      no_hit = '{1'b0, 1'b0, NONE, NONE};
      // plain x crossing at the origin
      add_row(mk(-5, -5, 5, 5, -5, 5, 5, -5), 1, '{1'b1, 1'b0, 0, 0});
      // disjoint, not parallel
      add_row(mk(0, 0, 1, 1, 10, 0, 11, -3), 1, no_hit);
      // parallel, apart
      add_row(mk(0, 0, 10, 0, 0, 1, 10, 1), 1, '{1'b0, 1'b1, NONE, NONE});
      // collinear overlap meets but reports no point
      add_row(mk(0, 0, 10, 0, 5, 0, 15, 0), 1, '{1'b1, 1'b1, NONE, NONE});
      // collinear, apart
      add_row(mk(0, 0, 10, 0, 11, 0, 15, 0), 1, '{1'b0, 1'b1, NONE, NONE});
      // zero-length segment lying on the other
      add_row(mk(3, 0, 3, 0, 0, 0, 10, 0), 1, '{1'b1, 1'b1, NONE, NONE});
      // both zero length, same point
      add_row(mk(7, 7, 7, 7, 7, 7, 7, 7), 1, '{1'b1, 1'b1, NONE, NONE});
      // touching at a shared endpoint
      add_row(mk(0, 0, 4, 4, 4, 4, 8, 0), 1, '{1'b1, 1'b0, 4, 4});
      // t-junction: endpoint on the other segment
      add_row(mk(0, 0, 10, 0, 5, 0, 5, 9), 1, '{1'b1, 1'b0, 5, 0});
      // rounding halves away from zero, both signs
      add_row(mk(0, 0, 1, 1, 0, 1, 1, 0), 0, no_hit);
      add_row(mk(0, 0, -1, -1, 0, -1, -1, 0), 0, no_hit);
      add_row(mk(0, 0, 3, 1, 0, 1, 3, 0), 0, no_hit);
      add_row(mk(0, 0, -3, -1, 0, -1, -3, 0), 0, no_hit);
      // full-range diagonals
      add_row(mk(CLO, CLO, CHI, CHI, CLO, CHI, CHI, CLO), 0, no_hit);
      add_row(mk(CHI, CLO, CLO, CHI, CLO, CLO, CHI, CHI), 0, no_hit);
      // extreme corners, parallel edges
      add_row(mk(CLO, CLO, CHI, CLO, CLO, CHI, CHI, CHI), 1, '{1'b0, 1'b1, NONE, NONE});
      // crossing at an extreme corner
      add_row(mk(CHI, CHI, CLO, CHI, CHI, CLO, CHI, CHI), 1, '{1'b1, 1'b0, CHI, CHI});
      add_row(mk(CLO, CLO, CHI, CLO, CLO, CHI, CLO, CLO), 1, '{1'b1, 1'b0, CLO, CLO});
      // all ones and a near-miss across the extremes
      add_row(mk(-1, -1, -1, -1, -1, -1, -1, -1), 1, '{1'b1, 1'b1, NONE, NONE});
      add_row(mk(CLO, 0, CHI, 1, 0, CLO, 1, CHI), 0, no_hit);
      add_row(mk(CLO, CHI, CHI, CLO, CLO, CHI - 1, CHI - 1, CLO), 0, no_hit);
   end

   // one transfer on the request side, with a random gap before it
   task automatic send_pair(seg_pair_type s);
      int gap;
      gap = $urandom_range(8);
      if ($urandom_range(3) == 0) gap = 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.a_start_x <= s.ax0;
      req_chan.a_start_y <= s.ay0;
      req_chan.a_end_x   <= s.ax1;
      req_chan.a_end_y   <= s.ay1;
      req_chan.b_start_x <= s.bx0;
      req_chan.b_start_y <= s.by0;
      req_chan.b_end_x   <= s.bx1;
      req_chan.b_end_y   <= s.by1;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // stimulus: directed table, a drain pause, then the random stream
   initial begin
      seg_pair_type s;
      req_chan.valid <= 1'b0;
      req_chan.a_start_x <= '0; req_chan.a_start_y <= '0;
      req_chan.a_end_x   <= '0; req_chan.a_end_y   <= '0;
      req_chan.b_start_x <= '0; req_chan.b_start_y <= '0;
      req_chan.b_end_x   <= '0; req_chan.b_end_y   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         if (directed[i].has_expect)
            expect_result(directed[i].want);
         else
            expect_result(predict_crossing(directed[i].pair));
         send_pair(directed[i].pair);
      end
      req_chan.valid <= 1'b0;
      // let the pipe run dry before the random part
      wait (expected_crossings.size() == 0);
      for (int n = 0; n < N_RANDOM; n++) begin
         s = rand_pair();
         expect_result(predict_crossing(s));
         send_pair(s);
      end
      req_chan.valid <= 1'b0;
      sender_done = 1'b1;
   end

   // result side: random back-pressure, in-order field compare
   initial begin
      crossing_type want;
      int stall;
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = ($urandom_range(3) == 0) ? 0 : $urandom_range(8);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         if (expected_crossings.size() == 0) begin
            report_mismatch("unexpected transfer, cross_x", rsp_chan.cross_x, 0);
         end else begin
            want = expected_crossings.pop_front();
            if (rsp_chan.segments_meet !== want.meet)
               report_mismatch("segments_meet", rsp_chan.segments_meet, want.meet);
            if (rsp_chan.lines_parallel !== want.parallel)
               report_mismatch("lines_parallel", rsp_chan.lines_parallel, want.parallel);
            if (rsp_chan.cross_x !== want.px)
               report_mismatch("cross_x", rsp_chan.cross_x, want.px);
            if (rsp_chan.cross_y !== want.py)
               report_mismatch("cross_y", rsp_chan.cross_y, want.py);
         end
      end
   end

   // watchdog: cycles with no transfer on either side
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // end of run
   initial begin
      fork
         begin
            wait (sender_done && expected_crossings.size() == 0);
            repeat (2 * LATENCY + 20) @(posedge clock);
         end
         wait (idle_cycles >= WDOG_MAX);
      join_any
      disable fork;
      if (idle_cycles < WDOG_MAX && n_errors == 0 && expected_crossings.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
